@@ design/ppst_pkg.sv @@
// Shared types and constants for the polygon point and segment test block.
// No dependencies; imported by every module of the block.
package ppst_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_VERTICES_DEF = 64;
	localparam int COORD_BITS_DEF   = 12;

	// Fixed field widths
	localparam int OP_BITS     = 2;
	localparam int INDEX_BITS  = 6;
	localparam int COUNT_BITS  = 7;

	// Smallest vertex count that forms a polygon
	localparam int MIN_VERTICES = 3;

	// Transaction opcodes
	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD    = 2'd0,
		OP_POINT   = 2'd1,
		OP_SEGMENT = 2'd2
	} op_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Control that travels alongside one edge through the edge pipeline
	typedef struct packed {
		logic vld;       // real edge of the polygon
		logic is_point;  // point test (else segment test)
		logic last;      // final step of the ring rotation
	} edge_ctl_t;

endpackage

@@ design/ppst_cell.sv @@
// One vertex cell of the rotating vertex ring.
// Depends on ppst_pkg (defaults only).
module ppst_cell
	import ppst_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  shift,
	input  logic                  wr_en,
	input  logic [COORD_BITS-1:0] wr_x,
	input  logic [COORD_BITS-1:0] wr_y,
	input  logic [COORD_BITS-1:0] nxt_x,
	input  logic [COORD_BITS-1:0] nxt_y,
	output logic [COORD_BITS-1:0] x,
	output logic [COORD_BITS-1:0] y
);

	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;

	// Load from the write port, or take the neighbor's vertex while rotating
	always_ff @(posedge clk) begin
		if (wr_en) begin
			x_q <= wr_x;
			y_q <= wr_y;
		end else if (shift) begin
			x_q <= nxt_x;
			y_q <= nxt_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

@@ design/ppst_edge.sv @@
// Three-stage edge test: differences, products, cross-product signs.
// Depends on ppst_pkg (edge_ctl_t).
module ppst_edge
	import ppst_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  edge_ctl_t             in_ctl,
	input  logic [COORD_BITS-1:0] e0_x,
	input  logic [COORD_BITS-1:0] e0_y,
	input  logic [COORD_BITS-1:0] e1_x,
	input  logic [COORD_BITS-1:0] e1_y,
	input  logic [COORD_BITS-1:0] a_x,
	input  logic [COORD_BITS-1:0] a_y,
	input  logic [COORD_BITS-1:0] b_x,
	input  logic [COORD_BITS-1:0] b_y,
	output edge_ctl_t             out_ctl,
	output logic                  flag
);

	localparam int DW = COORD_BITS + 1;   // coordinate difference
	localparam int PW = 2 * DW;           // product
	localparam int TW = PW + 1;           // cross value

	function automatic logic signed [DW-1:0] sdiff(input logic [COORD_BITS-1:0] p,
		input logic [COORD_BITS-1:0] q);
		logic signed [DW-1:0] r;
		r = $signed({1'b0, p}) - $signed({1'b0, q});
		return r;
	endfunction

	// Each lane forms t = u*v - w*z
	logic signed [DW-1:0] u_d [4];
	logic signed [DW-1:0] v_d [4];
	logic signed [DW-1:0] w_d [4];
	logic signed [DW-1:0] z_d [4];
	logic                 straddle_d;
	logic                 dy_pos_d;

	logic signed [DW-1:0] u_s1 [4];
	logic signed [DW-1:0] v_s1 [4];
	logic signed [DW-1:0] w_s1 [4];
	logic signed [DW-1:0] z_s1 [4];
	logic                 straddle_s1;
	logic                 dy_pos_s1;
	edge_ctl_t            ctl_s1;

	logic signed [PW-1:0] puv_s2 [4];
	logic signed [PW-1:0] pwz_s2 [4];
	logic                 straddle_s2;
	logic                 dy_pos_s2;
	edge_ctl_t            ctl_s2;

	logic signed [TW-1:0] t_d [4];
	logic                 pos_d [4];
	logic                 neg_d [4];
	logic                 flag_d;

	logic                 flag_s3;
	edge_ctl_t            ctl_s3;

	// Operand selection: point test uses lane 0 only
	always_comb begin
		straddle_d = (e0_y > a_y) != (e1_y > a_y);
		dy_pos_d   = e1_y > e0_y;
		if (in_ctl.is_point) begin
			u_d[0] = sdiff(e1_x, e0_x);
			v_d[0] = sdiff(a_y, e0_y);
			w_d[0] = sdiff(a_x, e0_x);
			z_d[0] = sdiff(e1_y, e0_y);
		end else begin
			u_d[0] = sdiff(a_x, e0_x);
			v_d[0] = sdiff(b_y, e0_y);
			w_d[0] = sdiff(a_y, e0_y);
			z_d[0] = sdiff(b_x, e0_x);
		end
		// side of the edge end against the query segment
		u_d[1] = sdiff(a_x, e1_x);
		v_d[1] = sdiff(b_y, e1_y);
		w_d[1] = sdiff(a_y, e1_y);
		z_d[1] = sdiff(b_x, e1_x);
		// sides of the segment ends against the edge
		u_d[2] = sdiff(e0_x, a_x);
		v_d[2] = sdiff(e1_y, a_y);
		w_d[2] = sdiff(e0_y, a_y);
		z_d[2] = sdiff(e1_x, a_x);
		u_d[3] = sdiff(e0_x, b_x);
		v_d[3] = sdiff(e1_y, b_y);
		w_d[3] = sdiff(e0_y, b_y);
		z_d[3] = sdiff(e1_x, b_x);
	end

	// Stage 1: differences
	always_ff @(posedge clk) begin
		u_s1        <= u_d;
		v_s1        <= v_d;
		w_s1        <= w_d;
		z_s1        <= z_d;
		straddle_s1 <= straddle_d;
		dy_pos_s1   <= dy_pos_d;
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			puv_s2[k] <= PW'(u_s1[k]) * PW'(v_s1[k]);
			pwz_s2[k] <= PW'(w_s1[k]) * PW'(z_s1[k]);
		end
		straddle_s2 <= straddle_s1;
		dy_pos_s2   <= dy_pos_s1;
	end

	// Stage 3: cross values, signs and the per-edge decision
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			t_d[k]   = $signed({puv_s2[k][PW-1], puv_s2[k]})
				- $signed({pwz_s2[k][PW-1], pwz_s2[k]});
			neg_d[k] = t_d[k][TW-1];
			pos_d[k] = !t_d[k][TW-1] && (|t_d[k]);
		end
		if (ctl_s2.is_point) begin
			// edge straddles y and passes strictly right of the point
			flag_d = straddle_s2 && (dy_pos_s2 ? pos_d[0] : neg_d[0]);
		end else begin
			// strictly opposite sides, both ways
			flag_d = ((pos_d[0] && neg_d[1]) || (neg_d[0] && pos_d[1]))
				&& ((pos_d[2] && neg_d[3]) || (neg_d[2] && pos_d[3]));
		end
	end

	// Control travels with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			flag_s3 <= 1'b0;
		end else begin
			ctl_s1  <= in_ctl;
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			flag_s3 <= ctl_s2.vld && flag_d;
		end
	end

	assign out_ctl = ctl_s3;
	assign flag    = flag_s3;

	// Checks
	a_last_delay: assert property (@(posedge clk) disable iff (!arst_n)
		out_ctl.last |-> $past(in_ctl.last, 3))
		else $error("edge pipeline: last marker out of step");

	a_vld_delay: assert property (@(posedge clk) disable iff (!arst_n)
		out_ctl.vld |-> $past(in_ctl.vld, 3))
		else $error("edge pipeline: edge valid out of step");

	a_point_straddle: assert property (@(posedge clk) disable iff (!arst_n)
		(flag_s3 && ctl_s3.is_point) |-> $past(straddle_s2))
		else $error("edge pipeline: point toggle without straddle");

endmodule

@@ design/polygon_point_and_segment_test.sv @@
// Polygon point-in-polygon and segment-crossing test, top level.
// Depends on ppst_pkg, ppst_cell and ppst_edge.
// A load is written into its vertex cell on acceptance and gives no result.
// A query with at least three vertices makes one ring rotation of MAX_VERTICES
// steps, one edge per step, then drains the three-stage edge pipeline before
// its result is loaded; with fewer vertices the result is loaded directly.
// No new item is taken until the result of the current query has been loaded.
// Reset clears control and vertex_count; the vertex store is not cleared.
module polygon_point_and_segment_test
	import ppst_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [COUNT_BITS-1:0] cfg_wr_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [OP_BITS-1:0]    operation,
	input  logic [INDEX_BITS-1:0] vertex_index,
	input  logic [COORD_BITS-1:0] first_x,
	input  logic [COORD_BITS-1:0] first_y,
	input  logic [COORD_BITS-1:0] second_x,
	input  logic [COORD_BITS-1:0] second_y,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic                  hit
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int NW = (CW > COUNT_BITS) ? CW : COUNT_BITS;
	localparam int IW = ((AW > INDEX_BITS) ? AW : INDEX_BITS) + 1;
	localparam logic [AW-1:0] LAST_STEP = AW'(MAX_VERTICES - 1);

	state_t                state_q;
	state_t                state_d;
	logic [AW-1:0]         step_q;
	logic [NW-1:0]         n_q;
	logic                  is_point_q;
	logic [COORD_BITS-1:0] ax_q;
	logic [COORD_BITS-1:0] ay_q;
	logic [COORD_BITS-1:0] bx_q;
	logic [COORD_BITS-1:0] by_q;
	logic [COORD_BITS-1:0] v0x_q;
	logic [COORD_BITS-1:0] v0y_q;
	logic                  acc_q;
	logic                  result_valid_q;
	logic                  hit_q;
	logic [COUNT_BITS-1:0] vertex_count_q;

	logic                  item_fire;
	logic                  query_fire;
	logic                  load_fire;
	logic                  result_load;
	logic [NW-1:0]         count_wide;
	logic [NW-1:0]         n_sat;
	logic                  enough;
	logic [IW-1:0]         slot_wide;
	logic                  slot_ok;
	logic [NW-1:0]         step_wide;
	logic                  shift;

	logic [COORD_BITS-1:0] cell_x [MAX_VERTICES];
	logic [COORD_BITS-1:0] cell_y [MAX_VERTICES];

	edge_ctl_t             edge_in;
	edge_ctl_t             edge_out;
	logic [COORD_BITS-1:0] e1_x;
	logic [COORD_BITS-1:0] e1_y;
	logic                  edge_flag;

	// Transaction decode
	assign item_ready = (state_q == ST_IDLE);
	assign item_fire  = item_valid && item_ready;
	assign query_fire = item_fire && ((operation == OP_POINT) || (operation == OP_SEGMENT));
	assign slot_wide  = IW'(vertex_index);
	assign slot_ok    = slot_wide < IW'(MAX_VERTICES);
	assign load_fire  = item_fire && (operation == OP_LOAD) && slot_ok;

	// Vertex count in use, saturated to the store depth
	assign count_wide = NW'(vertex_count_q);
	assign n_sat      = (count_wide > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : count_wide;
	assign enough     = n_sat >= NW'(MIN_VERTICES);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// Vertex ring: cell i takes cell i+1 on each walk step
	assign shift = (state_q == ST_WALK);

	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_VERTICES;
		ppst_cell #(
			.COORD_BITS (COORD_BITS)
		) u_cell (
			.clk   (clk),
			.shift (shift),
			.wr_en (load_fire && (slot_wide == IW'(i))),
			.wr_x  (first_x),
			.wr_y  (first_y),
			.nxt_x (cell_x[NXT]),
			.nxt_y (cell_y[NXT]),
			.x     (cell_x[i]),
			.y     (cell_y[i])
		);
	end

	// Edge issue: head cell to its neighbor, closing edge back to vertex 0
	assign step_wide = NW'(step_q);

	always_comb begin
		edge_in          = '0;
		edge_in.vld      = shift && (step_wide < n_q);
		edge_in.is_point = is_point_q;
		edge_in.last     = shift && (step_q == LAST_STEP);
		if ((step_wide + NW'(1)) == n_q) begin
			e1_x = v0x_q;
			e1_y = v0y_q;
		end else begin
			e1_x = cell_x[1];
			e1_y = cell_y[1];
		end
	end

	ppst_edge #(
		.COORD_BITS (COORD_BITS)
	) u_edge (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ctl  (edge_in),
		.e0_x    (cell_x[0]),
		.e0_y    (cell_y[0]),
		.e1_x    (e1_x),
		.e1_y    (e1_y),
		.a_x     (ax_q),
		.a_y     (ay_q),
		.b_x     (bx_q),
		.b_y     (by_q),
		.out_ctl (edge_out),
		.flag    (edge_flag)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d     = state_q;
		result_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (query_fire) begin
					state_d = enough ? ST_WALK : ST_RESULT;
				end
			end
			ST_WALK: begin
				if (step_q == LAST_STEP) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (edge_out.last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!result_valid_q || result_ready) begin
					result_load = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Query capture and walk counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			n_q    <= '0;
			acc_q  <= 1'b0;
		end else begin
			if (query_fire) begin
				step_q <= '0;
				n_q    <= n_sat;
				acc_q  <= 1'b0;
			end else begin
				if (shift) begin
					step_q <= step_q + AW'(1);
				end
				// parity for point tests, any-crossing for segment tests
				if (edge_out.vld) begin
					if (edge_out.is_point) begin
						acc_q <= acc_q ^ edge_flag;
					end else begin
						acc_q <= acc_q | edge_flag;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_fire) begin
			is_point_q <= (operation == OP_POINT);
			ax_q       <= first_x;
			ay_q       <= first_y;
			bx_q       <= second_x;
			by_q       <= second_y;
			v0x_q      <= cell_x[0];
			v0y_q      <= cell_y[0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			hit_q <= acc_q;
		end
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;

	// Checks
	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		edge_out.last |-> (state_q == ST_DRAIN))
		else $error("final edge arrived outside drain");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!edge_out.vld && !edge_in.vld))
		else $error("edge in flight while idle");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(query_fire && enough) |=> ((state_q == ST_WALK) && (step_q == '0)))
		else $error("walk did not start at step zero");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		result_load |=> (result_valid_q && (state_q == ST_IDLE)))
		else $error("result not presented after load");

endmodule

@@ tb/polygon_point_and_segment_test_checker.sv @@
// Checker for the polygon point and segment test block: watches the config,
// input and result channels, predicts each query answer and compares it.
// Depends on ppst_pkg for field widths, opcodes and the minimum polygon size.
module polygon_point_and_segment_test_checker
	import ppst_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [COUNT_BITS-1:0]     cfg_wr_data,
	input  logic                      item_valid,
	input  logic                      item_ready,
	input  logic [OP_BITS-1:0]        operation,
	input  logic [INDEX_BITS-1:0]     vertex_index,
	input  logic [COORD_BITS_DEF-1:0] first_x,
	input  logic [COORD_BITS_DEF-1:0] first_y,
	input  logic [COORD_BITS_DEF-1:0] second_x,
	input  logic [COORD_BITS_DEF-1:0] second_y,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic                      hit,
	output int                        error_count,
	output int                        pending_hits
);

	localparam int TABLE_DEPTH = MAX_VERTICES_DEF;

	// Shadow copy of the vertex store and the count register
	logic [COORD_BITS_DEF-1:0] corner_x [TABLE_DEPTH];
	logic [COORD_BITS_DEF-1:0] corner_y [TABLE_DEPTH];
	logic [COUNT_BITS-1:0]     corner_count;

	// Answers of accepted queries, oldest first
	bit expected_hits [$];
	bit wanted_hit;

	// Counts above the table depth saturate
	function automatic int corners_in_use();
		return (corner_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(corner_count);
	endfunction

	function automatic int sign_of(input longint v);
		return (v == 0) ? 0 : ((v > 0) ? 1 : -1);
	endfunction

	// Side of p relative to the directed line a->b
	function automatic int side_of(input longint ax, input longint ay, input longint bx,
			input longint by, input longint px, input longint py);
		return sign_of((ax - px) * (by - py) - (ay - py) * (bx - px));
	endfunction

	// c and d strictly on opposite sides of line a->b; a zero side means contact only
	function automatic bit splits(input longint ax, input longint ay, input longint bx,
			input longint by, input longint cx, input longint cy, input longint dx,
			input longint dy);
		return side_of(ax, ay, bx, by, cx, cy) * side_of(ax, ay, bx, by, dx, dy) < 0;
	endfunction

	// Even-odd rule: each edge straddling ty strictly right of tx flips the answer
	function automatic bit point_inside(input longint tx, input longint ty);
		int     n;
		int     i;
		int     j;
		bit     in_poly;
		longint xi;
		longint yi;
		longint xj;
		longint yj;
		longint dy;
		longint lhs;
		longint rhs;
		n = corners_in_use();
		in_poly = 1'b0;
		if (n < MIN_VERTICES)
			return 1'b0;
		j = n - 1;
		for (i = 0; i < n; i++) begin
			xi = corner_x[i];
			yi = corner_y[i];
			xj = corner_x[j];
			yj = corner_y[j];
			if ((yi > ty) != (yj > ty)) begin
				// cross-multiplied form of the x-intercept compare
				dy = yj - yi;
				lhs = (tx - xi) * dy;
				rhs = (xj - xi) * (ty - yi);
				if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
					in_poly = !in_poly;
			end
			j = i;
		end
		return in_poly;
	endfunction

	// Proper crossing against every edge, closing edge included
	function automatic bit segment_crosses(input longint ax, input longint ay,
			input longint bx, input longint by);
		int     n;
		int     i;
		int     k;
		longint cx;
		longint cy;
		longint dx;
		longint dy;
		n = corners_in_use();
		if (n < MIN_VERTICES)
			return 1'b0;
		for (i = 0; i < n; i++) begin
			k = (i + 1 == n) ? 0 : i + 1;
			cx = corner_x[i];
			cy = corner_y[i];
			dx = corner_x[k];
			dy = corner_y[k];
			if (splits(ax, ay, bx, by, cx, cy, dx, dy) && splits(cx, cy, dx, dy, ax, ay, bx, by))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Sample all channels at the rising edge
	always @(posedge clk) begin
		if (!arst_n) begin
			corner_count = '0;
		end else begin
			if (cfg_wr_en)
				corner_count = cfg_wr_data;

			// result transaction: compare with the oldest answer
			if (result_valid && result_ready) begin
				if (expected_hits.size() == 0) begin
					error_count++;
					$display("%0t: result with no query outstanding, expected none, actual hit %0b",
						$time, hit);
				end else begin
					wanted_hit = expected_hits.pop_front();
					if (hit !== wanted_hit) begin
						error_count++;
						$display("%0t: hit mismatch, expected %0b, actual %0b",
							$time, wanted_hit, hit);
					end
				end
			end

			// input transaction: update the store or predict the answer
			if (item_valid && item_ready) begin
				case (operation)
					OP_LOAD: begin
						corner_x[vertex_index] = first_x;
						corner_y[vertex_index] = first_y;
					end
					OP_POINT:
						expected_hits = {expected_hits, point_inside(first_x, first_y)};
					OP_SEGMENT:
						expected_hits = {expected_hits, segment_crosses(first_x, first_y,
							second_x, second_y)};
					default: ; // unused code: dropped, no result
				endcase
			end
			pending_hits = expected_hits.size();
		end
	end

endmodule

@@ tb/polygon_point_and_segment_test_tb.sv @@
// Testbench top for polygon_point_and_segment_test: clock, reset, stimulus,
// random stalls on both channels and the final verdict.
// Depends on ppst_pkg, the block and polygon_point_and_segment_test_checker.
module polygon_point_and_segment_test_tb;
	import ppst_pkg::*;

	localparam int     CLK_HALF      = 10;
	localparam int     RESET_CYCLES  = 6;
	localparam int     SETTLE_CYCLES = MAX_VERTICES_DEF + 16;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     PHASE_MIX     = 50;
	localparam longint TIMEOUT_UNITS = 20_000_000;
	localparam int     MAX_COORD     = (1 << COORD_BITS_DEF) - 1;
	localparam int     MAX_SLOT      = (1 << INDEX_BITS) - 1;
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

	// How vertex and query coordinates are spread over the plane
	typedef enum int {
		SPREAD_FULL,
		SPREAD_GRID,
		SPREAD_CLUSTER,
		SPREAD_EDGES
	} spread_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	logic [COUNT_BITS-1:0]     cfg_wr_data;
	logic                      item_valid;
	logic                      item_ready;
	logic [OP_BITS-1:0]        operation;
	logic [INDEX_BITS-1:0]     vertex_index;
	logic [COORD_BITS_DEF-1:0] first_x;
	logic [COORD_BITS_DEF-1:0] first_y;
	logic [COORD_BITS_DEF-1:0] second_x;
	logic [COORD_BITS_DEF-1:0] second_y;
	logic                      result_valid;
	logic                      result_ready;
	logic                      hit;
	int                        error_count;
	int                        pending_hits;

	bit quiet;
	bit hold_request;
	int n_loads;
	int n_points;
	int n_segments;
	int n_ignored;
	int n_cfg;

	polygon_point_and_segment_test DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.vertex_index (vertex_index),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.hit          (hit)
	);

	polygon_point_and_segment_test_checker hit_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.vertex_index (vertex_index),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.hit          (hit),
		.error_count  (error_count),
		.pending_hits (pending_hits)
	);

	// Clock
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Run limit
	initial begin
		#(TIMEOUT_UNITS);
		$display("%0t: timeout, %0d query answers still outstanding", $time, pending_hits);
		$display("DONE: errors detected");
		$finish;
	end

	// Result side: random stall bursts, one long hold on request
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				result_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
		end
	end

	function automatic int pick_coord(input spread_t spread);
		int k;
		case (spread)
			SPREAD_GRID: begin
				// coarse grid: many shared x, y values and collinear edges
				k = $urandom_range(0, 8);
				return (k == 8) ? MAX_COORD : k * 512;
			end
			SPREAD_CLUSTER:
				return $urandom_range(1748, 2348);
			SPREAD_EDGES: begin
				k = $urandom_range(0, 5);
				case (k)
					0:       return 0;
					1:       return 1;
					2:       return 2048;
					3:       return MAX_COORD - 1;
					default: return MAX_COORD;
				endcase
			end
			default:
				return $urandom_range(0, MAX_COORD);
		endcase
	endfunction

	// Offer one transaction from a falling edge, hold it until accepted,
	// then maybe leave a gap
	task automatic send_item(input logic [OP_BITS-1:0] op, input int slot,
			input int fx, input int fy, input int sx, input int sy);
		item_valid   <= 1'b1;
		operation    <= op;
		vertex_index <= slot[INDEX_BITS-1:0];
		first_x      <= fx[COORD_BITS_DEF-1:0];
		first_y      <= fy[COORD_BITS_DEF-1:0];
		second_x     <= sx[COORD_BITS_DEF-1:0];
		second_y     <= sy[COORD_BITS_DEF-1:0];
		do
			@(posedge clk);
		while (!item_ready);
		case (op)
			OP_LOAD:    n_loads++;
			OP_POINT:   n_points++;
			OP_SEGMENT: n_segments++;
			default:    n_ignored++;
		endcase
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	// Sender waits for every outstanding answer, lets trailing loads settle,
	// then writes the count register
	task automatic set_vertex_count(input int setting);
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_hits != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= setting[COUNT_BITS-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		n_cfg++;
	endtask

	// One setting: load a fresh polygon into every slot in use, then a mix
	// of point and segment queries, vertex rewrites and unused codes
	task automatic run_phase(input int setting, input spread_t spread, input bit with_hold);
		int      corners;
		int      slot;
		int      roll;
		spread_t qs;
		set_vertex_count(setting);
		corners = (setting > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : setting;
		for (slot = 0; slot < corners; slot++)
			send_item(OP_LOAD, slot, pick_coord(spread), pick_coord(spread),
				$urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD));
		if (with_hold)
			hold_request = 1'b1;
		repeat (PHASE_MIX) begin
			roll = $urandom_range(0, 99);
			qs = ($urandom_range(0, 3) == 0) ? SPREAD_FULL : spread;
			if (roll < 40)
				send_item(OP_POINT, $urandom_range(0, MAX_SLOT), pick_coord(qs),
					pick_coord(qs), $urandom_range(0, MAX_COORD),
					$urandom_range(0, MAX_COORD));
			else if (roll < 78)
				send_item(OP_SEGMENT, $urandom_range(0, MAX_SLOT), pick_coord(qs),
					pick_coord(qs), pick_coord(qs), pick_coord(qs));
			else if (roll < 95)
				send_item(OP_LOAD, $urandom_range(0, MAX_SLOT), pick_coord(spread),
					pick_coord(spread), $urandom_range(0, MAX_COORD),
					$urandom_range(0, MAX_COORD));
			else
				send_item(OP_UNUSED, $urandom_range(0, MAX_SLOT),
					$urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
					$urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD));
		end
	endtask

	// Stimulus
	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		item_valid   = 1'b0;
		operation    = OP_LOAD;
		vertex_index = '0;
		first_x      = '0;
		first_y      = '0;
		second_x     = '0;
		second_y     = '0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: queries on an empty polygon and an ignored code
		send_item(OP_POINT, 0, 0, 0, 0, 0);
		send_item(OP_SEGMENT, 0, 0, 0, MAX_COORD, MAX_COORD);
		send_item(OP_UNUSED, MAX_SLOT, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
		// right triangle on the extremes of the plane, plus the top slot
		send_item(OP_LOAD, 0, 0, 0, 0, 0);
		send_item(OP_LOAD, 1, MAX_COORD, 0, MAX_COORD, MAX_COORD);
		send_item(OP_LOAD, 2, 0, MAX_COORD, 0, 0);
		send_item(OP_LOAD, MAX_SLOT, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD);
		set_vertex_count(MIN_VERTICES);
		send_item(OP_POINT, 0, 100, 100, 0, 0);               // well inside
		send_item(OP_POINT, 0, MAX_COORD, MAX_COORD, 0, 0);   // outside corner
		send_item(OP_POINT, 0, 0, 0, 0, 0);                   // on a vertex
		send_item(OP_POINT, 0, 2047, 2048, 0, 0);             // on the hypotenuse
		send_item(OP_POINT, 0, 0, 2000, 0, 0);                // on the left edge
		send_item(OP_POINT, 0, MAX_COORD, 0, 0, 0);           // query y equals vertex y
		send_item(OP_SEGMENT, 0, 0, 0, MAX_COORD, MAX_COORD); // proper crossing
		send_item(OP_SEGMENT, 0, 100, 0, 200, 0);             // collinear with an edge
		send_item(OP_SEGMENT, 0, 2000, 0, 2000, 100);         // touches an edge
		send_item(OP_SEGMENT, 0, 5, 5, 5, 5);                 // zero length
		send_item(OP_SEGMENT, 0, 10, 10, 20, 20);             // fully inside
		send_item(OP_SEGMENT, 0, MAX_COORD, MAX_COORD, 3000, MAX_COORD);
		send_item(OP_SEGMENT, 0, 0, MAX_COORD, MAX_COORD, 0); // along the hypotenuse
		send_item(OP_SEGMENT, 0, 2000, MAX_COORD, 2000, 0);
		// too few vertices
		set_vertex_count(MIN_VERTICES - 1);
		send_item(OP_POINT, 0, 100, 100, 0, 0);
		send_item(OP_SEGMENT, 0, 0, 0, MAX_COORD, MAX_COORD);

		// Random phases over several counts, extremes included
		run_phase(MAX_VERTICES_DEF, SPREAD_FULL, 1'b0);
		run_phase((1 << COUNT_BITS) - 1, SPREAD_GRID, 1'b0);
		run_phase(MIN_VERTICES, SPREAD_EDGES, 1'b1);
		run_phase($urandom_range(4, 12), SPREAD_CLUSTER, 1'b0);
		run_phase(0, SPREAD_FULL, 1'b0);
		run_phase($urandom_range(3, MAX_VERTICES_DEF), SPREAD_GRID, 1'b0);
		run_phase(MAX_VERTICES_DEF + 1, SPREAD_CLUSTER, 1'b0);
		run_phase(1, SPREAD_FULL, 1'b0);
		run_phase($urandom_range(3, 20), SPREAD_GRID, 1'b0);
		run_phase(2, SPREAD_EDGES, 1'b0);
		run_phase($urandom_range(3, MAX_VERTICES_DEF), SPREAD_FULL, 1'b0);
		// last stretch runs at full rate on both sides
		quiet = 1'b1;
		run_phase($urandom_range(5, 16), SPREAD_CLUSTER, 1'b0);

		// Drain and verdict
		item_valid <= 1'b0;
		@(negedge clk);
		while (pending_hits != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Covered %0d vertex loads, %0d point and %0d segment queries, %0d unused codes.",
			n_loads, n_points, n_segments, n_ignored);
		$display("Vertex count rewritten %0d times, from zero through the saturating maximum.",
			n_cfg);
		if (error_count == 0 && pending_hits == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
